/* src/icce_pkg.sv */
// shared constants, types and control structs for the clamped-edge convolution unit
package icce_pkg;

  // default sizing of the top level
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 3;
  localparam int COEF_BITS_DEF  = 16;

  // fixed plane height limit and register field widths
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;
  localparam int HGT_W      = 13;
  localparam int WIDTH_W    = 11;
  localparam int RADC_W     = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // register reset values
  localparam logic [WIDTH_W-1:0] WIDTH_RST = WIDTH_W'(1024);
  localparam logic [HGT_W-1:0]   HGT_RST   = HGT_W'(4096);
  localparam logic [RADC_W-1:0]  RAD_RST   = RADC_W'(1);

  // divisor used when the coefficient sum is zero (1.0 in Q8.8), and the output ceiling
  localparam int DIV_ONE = 256;
  localparam int PIX_MAX = 255;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_RADIUS_H     = 2'd2,
    CFG_RADIUS_V     = 2'd3
  } cfg_idx_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic idle;
    logic accept_pix;
    logic accept_coef;
    logic coef_upd;
    logic tap_clear;
    logic tap_mac;
    logic div_load;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic has_out;
    logic tap_last;
    logic div_last;
    logic out_free;
    logic out_last;
  } ctrl_sts_t;

endpackage

/* src/icce_ctrl.sv */
// controller state machine sequencing loads, taps, division and result hand-off
module icce_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_action,
  output logic               in_stall,
  input  icce_pkg::ctrl_sts_t sts,
  output icce_pkg::ctrl_cmd_t cmd
);
  import icce_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_COEF     = 8'b0000_0010,
    S_PIX      = 8'b0000_0100,
    S_TAP_RD   = 8'b0000_1000,
    S_TAP_MAC  = 8'b0001_0000,
    S_DIV_LOAD = 8'b0010_0000,
    S_DIV_RUN  = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (accept) begin
          cmd.accept_pix  = in_action;
          cmd.accept_coef = !in_action;
          state_nxt       = in_action ? S_PIX : S_COEF;
        end
      end
      S_COEF: begin
        cmd.coef_upd = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_PIX: begin
        if (sts.has_out) begin
          cmd.tap_clear = 1'b1;
          state_nxt     = S_TAP_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_TAP_RD: begin
        state_nxt = S_TAP_MAC;
      end
      S_TAP_MAC: begin
        cmd.tap_mac = 1'b1;
        state_nxt   = sts.tap_last ? S_DIV_LOAD : S_TAP_RD;
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.tap_clear = 1'b1;
            state_nxt     = S_TAP_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/icce_dp.sv */
// datapath: registers, position tracking, line and coefficient memories, mac and divider
module icce_dp #(
  parameter int MAX_WIDTH  = icce_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = icce_pkg::MAX_RADIUS_DEF,
  parameter int COEF_BITS  = icce_pkg::COEF_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  icce_pkg::ctrl_cmd_t                          cmd,
  output icce_pkg::ctrl_sts_t                          sts,
  input  logic                                         cfg_valid,
  input  logic [icce_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [icce_pkg::CFG_DATA_W-1:0]              cfg_data,
  input  logic                                         in_frame_start,
  input  logic [$clog2((2*MAX_RADIUS+1)**2)-1:0]       in_coef_index,
  input  logic signed [COEF_BITS-1:0]                  in_coef_value,
  input  logic [7:0]                                   in_pixel_value,
  input  logic                                         out_stall,
  output logic                                         out_valid,
  output logic [7:0]                                   out_pixel_out,
  output logic [$clog2(MAX_WIDTH)-1:0]                 out_out_column,
  output logic [icce_pkg::ROW_W-1:0]                   out_out_row,
  output logic                                         out_last
);
  import icce_pkg::*;

  localparam int KDIM    = 2 * MAX_RADIUS + 1;
  localparam int KSLOTS  = KDIM * KDIM;
  localparam int IDX_W   = $clog2(KSLOTS);
  localparam int K_W     = $clog2(KDIM);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WEFF_W  = COL_W + 1;
  localparam int CX      = COL_W + 2;
  localparam int SX      = ROW_W + 2;
  localparam int LINES   = KDIM * MAX_WIDTH;
  localparam int LADDR_W = $clog2(LINES);
  localparam int SUM_W   = COEF_BITS + $clog2(KSLOTS);
  localparam int PROD_W  = COEF_BITS + 9;
  localparam int ACC_W   = COEF_BITS + 9 + $clog2(KSLOTS);
  localparam int CNT_W   = $clog2(ACC_W + 1);

  // configuration registers
  logic [WIDTH_W-1:0] width_r;
  logic [HGT_W-1:0]   height_r;
  logic [RADC_W-1:0]  rad_h_r, rad_v_r;

  // raster position
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [K_W-1:0]   rmod_r, rmod_nxt;

  // current item
  logic [ROW_W-1:0] y_r, y1_r, oy_r;
  logic [K_W-1:0]   ymod_r;
  logic [COL_W-1:0] x0_r, x1_r, ox_r;
  logic             has_out_r;

  // coefficient store
  logic signed [COEF_BITS-1:0] cmem [KSLOTS];
  logic [KSLOTS-1:0]           cvalid_r;
  logic signed [COEF_BITS-1:0] cmem_q;
  logic                        cvq_r;
  logic [IDX_W-1:0]            cidx_r, crd_addr;
  logic                        cidx_ok_r;
  logic signed [COEF_BITS-1:0] cval_r;
  logic signed [COEF_BITS-1:0] coef_q;
  logic signed [SUM_W-1:0]     sum_r;

  // line store
  logic [7:0]         lmem [LINES];
  logic [7:0]         lmem_q;
  logic [LADDR_W-1:0] lwr_addr, lrd_addr;

  // tap loop and accumulator
  logic [K_W-1:0]           kx_r, ky_r;
  logic [IDX_W-1:0]         slot_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod;

  // divider
  logic [ACC_W-1:0]        quo_r;
  logic [SUM_W-1:0]        rem_r, dmag_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    neg_r;
  logic signed [SUM_W-1:0] dv;
  logic [SUM_W:0]          shv;
  logic [7:0]              res;

  // effective register values
  logic [WEFF_W-1:0] weff;
  logic [HGT_W-1:0]  heff;
  logic [K_W-1:0]    rh, rv, rh2, rv2;

  // position calculation on a pixel request
  logic [COL_W-1:0]    col_a;
  logic [HGT_W-1:0]    row_a;
  logic [K_W-1:0]      mod_a;
  logic [ROW_W-1:0]    y_a, y0_a, y1_a;
  logic [COL_W-1:0]    x0_a, x1_a;
  logic                hx, hy;
  logic signed [SX-1:0] ym;
  logic signed [CX-1:0] xm;

  // tap address
  logic signed [SX-1:0] yy_s;
  logic signed [CX-1:0] xx_s;
  logic [ROW_W-1:0]     yy;
  logic [COL_W-1:0]     xx;
  logic [K_W-1:0]       row_back, slot_row;

  always_comb begin
    if (width_r == '0) begin
      weff = WEFF_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      weff = WEFF_W'(MAX_WIDTH);
    end else begin
      weff = WEFF_W'(width_r);
    end
    if (height_r == '0) begin
      heff = HGT_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      heff = HGT_W'(MAX_HEIGHT);
    end else begin
      heff = height_r;
    end
    rh  = (32'(rad_h_r) > MAX_RADIUS) ? K_W'(MAX_RADIUS) : K_W'(rad_h_r);
    rv  = (32'(rad_v_r) > MAX_RADIUS) ? K_W'(MAX_RADIUS) : K_W'(rad_v_r);
    rh2 = K_W'({rh, 1'b0});
    rv2 = K_W'({rv, 1'b0});
  end

  // position, next position and output window of a pixel request
  always_comb begin
    col_a = in_frame_start ? '0 : col_r;
    row_a = in_frame_start ? '0 : {1'b0, row_r};
    mod_a = in_frame_start ? '0 : rmod_r;
    if ({1'b0, col_a} >= weff) begin
      col_a = '0;
      row_a = row_a + HGT_W'(1);
      mod_a = (mod_a == K_W'(KDIM - 1)) ? '0 : mod_a + K_W'(1);
    end
    if (row_a >= heff) begin
      row_a = '0;
      mod_a = '0;
    end
    y_a = row_a[ROW_W-1:0];

    if (({1'b0, col_a} + WEFF_W'(1)) >= weff) begin
      col_nxt = '0;
      if ((row_a + HGT_W'(1)) >= heff) begin
        row_nxt  = '0;
        rmod_nxt = '0;
      end else begin
        row_nxt  = y_a + ROW_W'(1);
        rmod_nxt = (mod_a == K_W'(KDIM - 1)) ? '0 : mod_a + K_W'(1);
      end
    end else begin
      col_nxt  = col_a + COL_W'(1);
      row_nxt  = y_a;
      rmod_nxt = mod_a;
    end

    ym = $signed({2'b00, y_a}) - $signed(SX'(rv));
    if (row_a == heff - HGT_W'(1)) begin
      y0_a = ym[SX-1] ? '0 : ym[ROW_W-1:0];
      y1_a = y_a;
      hy   = 1'b1;
    end else if (!ym[SX-1]) begin
      y0_a = ym[ROW_W-1:0];
      y1_a = ym[ROW_W-1:0];
      hy   = 1'b1;
    end else begin
      y0_a = '0;
      y1_a = '0;
      hy   = 1'b0;
    end

    xm = $signed({2'b00, col_a}) - $signed(CX'(rh));
    if ({1'b0, col_a} == weff - WEFF_W'(1)) begin
      x0_a = xm[CX-1] ? '0 : xm[COL_W-1:0];
      x1_a = col_a;
      hx   = 1'b1;
    end else if (!xm[CX-1]) begin
      x0_a = xm[COL_W-1:0];
      x1_a = xm[COL_W-1:0];
      hx   = 1'b1;
    end else begin
      x0_a = '0;
      x1_a = '0;
      hx   = 1'b0;
    end

    lwr_addr = LADDR_W'(32'(mod_a) * MAX_WIDTH) + LADDR_W'(col_a);
  end

  // clamped tap coordinates and their line slot
  always_comb begin
    yy_s = $signed({2'b00, oy_r}) - $signed(SX'(rv)) + $signed(SX'(ky_r));
    if (yy_s[SX-1]) begin
      yy = '0;
    end else if (yy_s > $signed({1'b0, heff}) - SX'(1)) begin
      yy = ROW_W'(heff - HGT_W'(1));
    end else begin
      yy = yy_s[ROW_W-1:0];
    end
    xx_s = $signed({2'b00, ox_r}) - $signed(CX'(rh)) + $signed(CX'(kx_r));
    if (xx_s[CX-1]) begin
      xx = '0;
    end else if (xx_s > $signed({1'b0, weff}) - CX'(1)) begin
      xx = COL_W'(weff - WEFF_W'(1));
    end else begin
      xx = xx_s[COL_W-1:0];
    end
    // window rows never reach further back than the line store holds
    row_back = K_W'(y_r - yy);
    if (ymod_r >= row_back) begin
      slot_row = ymod_r - row_back;
    end else begin
      slot_row = K_W'({1'b0, ymod_r} + (K_W+1)'(KDIM) - {1'b0, row_back});
    end
    lrd_addr = LADDR_W'(32'(slot_row) * MAX_WIDTH) + LADDR_W'(xx);
  end

  // coefficient read address: request index while idle, tap slot otherwise
  always_comb begin
    if (cmd.idle) begin
      crd_addr = (32'(in_coef_index) < KSLOTS) ? in_coef_index : '0;
    end else begin
      crd_addr = slot_r;
    end
  end

  assign coef_q = cvq_r ? cmem_q : '0;
  assign prod   = PROD_W'($signed({1'b0, lmem_q})) * PROD_W'(coef_q);

  // divisor and one restoring step
  assign dv  = (sum_r == '0) ? SUM_W'(DIV_ONE) : sum_r;
  assign shv = {rem_r, quo_r[ACC_W-1]};
  always_comb begin
    if (neg_r) begin
      res = '0;
    end else if (quo_r > ACC_W'(PIX_MAX)) begin
      res = 8'(PIX_MAX);
    end else begin
      res = quo_r[7:0];
    end
  end

  // status to the controller
  always_comb begin
    sts.has_out  = has_out_r;
    sts.tap_last = (kx_r == rh2) && (ky_r == rv2);
    sts.div_last = (cnt_r == CNT_W'(1));
    sts.out_free = !out_valid || !out_stall;
    sts.out_last = (ox_r == x1_r) && (oy_r == y1_r);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HGT_RST;
      rad_h_r  <= RAD_RST;
      rad_v_r  <= RAD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
        CFG_RADIUS_H:     rad_h_r  <= cfg_data[RADC_W-1:0];
        CFG_RADIUS_V:     rad_v_r  <= cfg_data[RADC_W-1:0];
        default:          width_r  <= width_r;
      endcase
    end
  end

  // raster position and coefficient sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      rmod_r <= '0;
      sum_r  <= '0;
    end else begin
      if (cmd.accept_pix) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        rmod_r <= rmod_nxt;
      end
      if (cmd.coef_upd && cidx_ok_r) begin
        sum_r <= sum_r + SUM_W'(cval_r) - SUM_W'(coef_q);
      end
    end
  end

  // item registers and output walk
  always_ff @(posedge clk) begin
    if (cmd.accept_pix) begin
      y_r       <= y_a;
      ymod_r    <= mod_a;
      x0_r      <= x0_a;
      x1_r      <= x1_a;
      y1_r      <= y1_a;
      ox_r      <= x0_a;
      oy_r      <= y0_a;
      has_out_r <= hx && hy;
    end else if (cmd.emit) begin
      if (ox_r == x1_r) begin
        ox_r <= x0_r;
        oy_r <= oy_r + ROW_W'(1);
      end else begin
        ox_r <= ox_r + COL_W'(1);
      end
    end
    if (cmd.accept_coef) begin
      cidx_r    <= in_coef_index;
      cidx_ok_r <= 32'(in_coef_index) < KSLOTS;
      cval_r    <= in_coef_value;
    end
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (cmd.coef_upd && cidx_ok_r) begin
      cmem[cidx_r] <= cval_r;
    end
    cmem_q <= cmem[crd_addr];
  end

  // coefficient valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r <= '0;
      cvq_r    <= 1'b0;
    end else begin
      if (cmd.coef_upd && cidx_ok_r) begin
        cvalid_r[cidx_r] <= 1'b1;
      end
      cvq_r <= cvalid_r[crd_addr];
    end
  end

  // line memory
  always_ff @(posedge clk) begin
    if (cmd.accept_pix) begin
      lmem[lwr_addr] <= in_pixel_value;
    end
    lmem_q <= lmem[lrd_addr];
  end

  // tap loop and multiply-accumulate
  always_ff @(posedge clk) begin
    if (cmd.tap_clear) begin
      kx_r   <= '0;
      ky_r   <= '0;
      slot_r <= '0;
      acc_r  <= '0;
    end else if (cmd.tap_mac) begin
      if (kx_r == rh2) begin
        kx_r <= '0;
        ky_r <= ky_r + K_W'(1);
      end else begin
        kx_r <= kx_r + K_W'(1);
      end
      slot_r <= slot_r + IDX_W'(1);
      acc_r  <= acc_r + ACC_W'(prod);
    end
  end

  // restoring divider on magnitudes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo_r  <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
      dmag_r <= dv[SUM_W-1] ? SUM_W'(-dv) : SUM_W'(dv);
      neg_r  <= acc_r[ACC_W-1] ^ dv[SUM_W-1];
      rem_r  <= '0;
      cnt_r  <= CNT_W'(ACC_W);
    end else if (cmd.div_step) begin
      if (shv >= {1'b0, dmag_r}) begin
        rem_r <= SUM_W'(shv - {1'b0, dmag_r});
        quo_r <= {quo_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_r <= shv[SUM_W-1:0];
        quo_r <= {quo_r[ACC_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pixel_out  <= res;
      out_out_column <= ox_r;
      out_out_row    <= oy_r;
      out_last       <= sts.out_last;
    end
  end

endmodule

/* src/image_convolution_clamped_edges_unit.sv */
// top level of the streaming 2d convolution with clamp-to-edge borders
//
// Input channel (in_valid / in_stall): one request is either a kernel coefficient
// (in_action low) or a pixel of the plane in raster order (in_action high);
// in_frame_start marks the first pixel of a plane. A request is taken when
// in_valid is high and in_stall is low.
// Result channel (out_valid / out_stall): each pixel request yields zero or more
// results with their column and row; out_last flags the final one of a request.
// Configuration (cfg_valid / cfg_ready): width, height and the two kernel radii, to be
// written by the user only while no request is in flight, which the block does not enforce;
// cfg_ready is always high. Per result, a pixel runs a tap loop over the (2*rh+1)*(2*rv+1)
// taps, which shares one multiplier and one line-store read port, then the one-bit-per-cycle
// divider and a hand-off to the output register; a stalled output stretches the hand-off.
// One request at a time. Reset clears the coefficients, their sum, the raster position and
// the output register; line-store contents are undefined until written. A stalled result
// holds in the output register while the next one is computed behind it.
module image_convolution_clamped_edges_unit #(
  parameter int MAX_WIDTH  = icce_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = icce_pkg::MAX_RADIUS_DEF,
  parameter int COEF_BITS  = icce_pkg::COEF_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [icce_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [icce_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_action,
  input  logic                                   in_frame_start,
  input  logic [$clog2((2*MAX_RADIUS+1)**2)-1:0] in_coef_index,
  input  logic signed [COEF_BITS-1:0]            in_coef_value,
  input  logic [7:0]                             in_pixel_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [7:0]                             out_pixel_out,
  output logic [$clog2(MAX_WIDTH)-1:0]           out_out_column,
  output logic [icce_pkg::ROW_W-1:0]             out_out_row,
  output logic                                   out_last
);
  import icce_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // the user must issue writes only while idle (the block does not enforce it); the port never pushes back
  assign cfg_ready = 1'b1;

  // sequencer
  icce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  icce_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .COEF_BITS  (COEF_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_frame_start (in_frame_start),
    .in_coef_index  (in_coef_index),
    .in_coef_value  (in_coef_value),
    .in_pixel_value (in_pixel_value),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_pixel_out  (out_pixel_out),
    .out_out_column (out_out_column),
    .out_out_row    (out_out_row),
    .out_last       (out_last)
  );

endmodule

/* src/icce_chk.sv */
// port-level checker for the convolution unit and its bind
module icce_chk #(
  parameter int MAX_WIDTH = icce_pkg::MAX_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [7:0]                   out_pixel_out,
  input logic [$clog2(MAX_WIDTH)-1:0] out_out_column,
  input logic [icce_pkg::ROW_W-1:0]   out_out_row,
  input logic                         out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out) &&
      $stable(out_out_column) && $stable(out_out_row) && $stable(out_last))
    else $error("stalled result changed");

  // reset leaves the block empty and ready for a request
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // the block is busy in the cycle after every accepted request
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request not followed by busy cycle");

endmodule

bind image_convolution_clamped_edges_unit icce_chk #(.MAX_WIDTH(MAX_WIDTH)) u_icce_chk (.*);
